/* rtl/imd_pkg.sv */
// ----------------------------------------------------------------------------
// imd_pkg
// Shared types and constants for the IMU packet deframer.
// ----------------------------------------------------------------------------
package imd_pkg;

  // Sync sequence bytes and record tags
  localparam logic [7:0] SYNC_B0 = 8'hFF;
  localparam logic [7:0] SYNC_B1 = 8'hF0;
  localparam logic [7:0] SYNC_B2 = 8'h00;

  localparam logic [7:0] TAG_QUAT   = 8'h01;
  localparam logic [7:0] TAG_SKIP_A = 8'h02;
  localparam logic [7:0] TAG_ACCEL  = 8'h04;
  localparam logic [7:0] TAG_SKIP_B = 8'h06;
  localparam logic [7:0] TAG_TIME   = 8'h08;

  // Record lengths in bytes
  localparam int TIME_RECORD_BYTES = 8;
  localparam logic [4:0] QUAT_BYTES   = 5'd16;
  localparam logic [4:0] ACCEL_BYTES  = 5'd12;
  localparam logic [4:0] SKIP12_BYTES = 5'd12;
  localparam logic [4:0] TIME_BYTES   = 5'(TIME_RECORD_BYTES);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CHK0 = 3'd1,
    PH_CHK1 = 3'd2,
    PH_LEN  = 3'd3,
    PH_BODY = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    RK_TAG    = 3'd0,
    RK_QUAT   = 3'd1,
    RK_ACCEL  = 3'd2,
    RK_SKIP12 = 3'd3,
    RK_SKIPT  = 3'd4
  } rkind_t;

  // One result item
  typedef struct packed {
    logic [31:0] quat_w;
    logic [31:0] quat_x;
    logic [31:0] quat_y;
    logic [31:0] quat_z;
    logic [31:0] accel_x;
    logic [31:0] accel_y;
    logic [31:0] accel_z;
    logic [31:0] packet_seq;
  } result_t;

endpackage

/* rtl/imu_packet_deframer.sv */
// ----------------------------------------------------------------------------
// imu_packet_deframer
// Byte-stream deframer for IMU packets: sync, check byte, tagged records.
// ----------------------------------------------------------------------------
// Path: the last body byte is held in the input register, then the parse
//   logic loads the result register, unless a full result register stalls it.
// Throughput: one byte per cycle while in_stall is low, set by the single-pass parse update.
// Reset: synchronous active-low rst_n clears parse state, held values and
//   the packet count; staged record words are not reset.
module imu_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_quat_w,
  output logic [31:0] out_quat_x,
  output logic [31:0] out_quat_y,
  output logic [31:0] out_quat_z,
  output logic [31:0] out_accel_x,
  output logic [31:0] out_accel_y,
  output logic [31:0] out_accel_z,
  output logic [31:0] out_packet_seq
);
  import imd_pkg::*;

  logic       byte_vld_r, byte_vld_nxt;
  logic [7:0] byte_r;
  logic       room;
  logic       step;
  logic       emit;
  result_t    result;
  result_t    out_data;

  // Parse the held byte when the result register can take a request
  assign step     = byte_vld_r && room;
  assign in_stall = byte_vld_r && !room;

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (!in_stall) byte_vld_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
    end
  end

  // Capture incoming byte
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) byte_r <= in_rx_byte;
  end

  imd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (byte_r),
    .emit    (emit),
    .result  (result)
  );

  imd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && emit),
    .load_data (result),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_quat_w     = out_data.quat_w;
  assign out_quat_x     = out_data.quat_x;
  assign out_quat_y     = out_data.quat_y;
  assign out_quat_z     = out_data.quat_z;
  assign out_accel_x    = out_data.accel_x;
  assign out_accel_y    = out_data.accel_y;
  assign out_accel_z    = out_data.accel_z;
  assign out_packet_seq = out_data.packet_seq;

endmodule

/* rtl/imd_parser.sv */
// ----------------------------------------------------------------------------
// imd_parser
// Per-byte packet parser: sync hunt, header, record staging and commit.
// ----------------------------------------------------------------------------
module imd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output logic             emit,
  output imd_pkg::result_t result
);
  import imd_pkg::*;

  phase_t      phase_r,    phase_nxt;
  logic [15:0] window_r,   window_nxt;
  logic [7:0]  check_r,    check_nxt;
  logic [7:0]  length_r,   length_nxt;
  logic [7:0]  count_r,    count_nxt;
  logic [7:0]  or_r,       or_nxt;
  rkind_t      kind_r,     kind_nxt;
  logic [4:0]  offset_r,   offset_nxt;
  logic        qseen_r,    qseen_nxt;
  logic        aseen_r,    aseen_nxt;
  logic [31:0] squat_r [4];
  logic [31:0] squat_nxt [4];
  logic [31:0] saccel_r [3];
  logic [31:0] saccel_nxt [3];
  logic [31:0] hquat_r [4];
  logic [31:0] hquat_nxt [4];
  logic [31:0] haccel_r [3];
  logic [31:0] haccel_nxt [3];
  logic [31:0] pkts_r,     pkts_nxt;

  logic [4:0]  off_inc;
  logic [8:0]  cnt_inc;
  logic        finish;
  logic [7:0]  or_final;
  logic        qseen_pre;
  logic        aseen_pre;

  assign off_inc = offset_r + 5'd1;
  assign cnt_inc = {1'b0, count_r} + 9'd1;

  // Compute next parse state for the byte at hand
  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    check_nxt  = check_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    or_nxt     = or_r;
    kind_nxt   = kind_r;
    offset_nxt = offset_r;
    qseen_nxt  = qseen_r;
    aseen_nxt  = aseen_r;
    squat_nxt  = squat_r;
    saccel_nxt = saccel_r;
    finish     = 1'b0;
    or_final   = or_r;

    unique case (phase_r)
      PH_HUNT: begin
        if (window_r == {SYNC_B0, SYNC_B1} && rx_byte == SYNC_B2) begin
          window_nxt = 16'd0;
          phase_nxt  = PH_CHK0;
        end else begin
          window_nxt = {window_r[7:0], rx_byte};
        end
      end
      PH_CHK0: phase_nxt = PH_CHK1;
      PH_CHK1: begin
        check_nxt = rx_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        length_nxt = rx_byte;
        count_nxt  = 8'd0;
        or_nxt     = 8'd0;
        or_final   = 8'd0;
        kind_nxt   = RK_TAG;
        offset_nxt = 5'd0;
        if (rx_byte == 8'd0) begin
          finish = 1'b1;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        or_nxt    = or_r | rx_byte;
        or_final  = or_r | rx_byte;
        count_nxt = cnt_inc[7:0];
        case (kind_r)
          RK_QUAT: begin
            squat_nxt[offset_r[3:2]][{offset_r[1:0], 3'b000} +: 8] = rx_byte;
            offset_nxt = off_inc;
            if (off_inc >= QUAT_BYTES) begin
              qseen_nxt = 1'b1;
              kind_nxt  = RK_TAG;
            end
          end
          RK_ACCEL: begin
            if (offset_r < ACCEL_BYTES) begin
              saccel_nxt[offset_r[3:2]][{offset_r[1:0], 3'b000} +: 8] = rx_byte;
            end
            offset_nxt = off_inc;
            if (off_inc >= ACCEL_BYTES) begin
              aseen_nxt = 1'b1;
              kind_nxt  = RK_TAG;
            end
          end
          RK_SKIP12: begin
            offset_nxt = off_inc;
            if (off_inc >= SKIP12_BYTES) kind_nxt = RK_TAG;
          end
          RK_SKIPT: begin
            offset_nxt = off_inc;
            if (off_inc >= TIME_BYTES) kind_nxt = RK_TAG;
          end
          default: begin
            offset_nxt = 5'd0;
            case (rx_byte)
              TAG_QUAT: begin
                kind_nxt  = RK_QUAT;
                qseen_nxt = 1'b0;
              end
              TAG_ACCEL: begin
                kind_nxt  = RK_ACCEL;
                aseen_nxt = 1'b0;
              end
              TAG_SKIP_A, TAG_SKIP_B: kind_nxt = RK_SKIP12;
              TAG_TIME:               kind_nxt = RK_SKIPT;
              default:                kind_nxt = RK_TAG;
            endcase
          end
        endcase
        if (cnt_inc >= {1'b0, length_r}) finish = 1'b1;
      end
      default: finish = 1'b1;
    endcase

    // Seen flags as they stand after this byte, before the end-of-packet clear
    qseen_pre = qseen_nxt;
    aseen_pre = aseen_nxt;

    // Drop packet state after the last byte; restart the hunt
    if (finish) begin
      phase_nxt  = PH_HUNT;
      window_nxt = 16'd0;
      check_nxt  = 8'd0;
      length_nxt = 8'd0;
      count_nxt  = 8'd0;
      or_nxt     = 8'd0;
      kind_nxt   = RK_TAG;
      offset_nxt = 5'd0;
      qseen_nxt  = 1'b0;
      aseen_nxt  = 1'b0;
    end
  end

  // Commit staged records on a packet whose check byte matches
  always_comb begin
    hquat_nxt  = hquat_r;
    haccel_nxt = haccel_r;
    pkts_nxt   = pkts_r;
    emit       = 1'b0;
    if (finish && phase_r != PH_HUNT && phase_r != PH_CHK0 && phase_r != PH_CHK1 &&
        or_final == check_r) begin
      emit = 1'b1;
      if (qseen_pre) hquat_nxt = squat_nxt;
      if (aseen_pre) haccel_nxt = saccel_nxt;
      pkts_nxt = pkts_r + 32'd1;
    end
  end

  // Result payload: held values after commit and the prior packet count
  always_comb begin
    result.quat_w     = hquat_nxt[0];
    result.quat_x     = hquat_nxt[1];
    result.quat_y     = hquat_nxt[2];
    result.quat_z     = hquat_nxt[3];
    result.accel_x    = haccel_nxt[0];
    result.accel_y    = haccel_nxt[1];
    result.accel_z    = haccel_nxt[2];
    result.packet_seq = pkts_r;
  end

  // Advance control state on each consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      window_r <= 16'd0;
      check_r  <= 8'd0;
      length_r <= 8'd0;
      count_r  <= 8'd0;
      or_r     <= 8'd0;
      kind_r   <= RK_TAG;
      offset_r <= 5'd0;
      qseen_r  <= 1'b0;
      aseen_r  <= 1'b0;
      hquat_r  <= '{default: 32'd0};
      haccel_r <= '{default: 32'd0};
      pkts_r   <= 32'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      window_r <= window_nxt;
      check_r  <= check_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      or_r     <= or_nxt;
      kind_r   <= kind_nxt;
      offset_r <= offset_nxt;
      qseen_r  <= qseen_nxt;
      aseen_r  <= aseen_nxt;
      hquat_r  <= hquat_nxt;
      haccel_r <= haccel_nxt;
      pkts_r   <= pkts_nxt;
    end
  end

  // Hold staged record words; no reset needed
  always_ff @(posedge clk) begin
    if (step) begin
      squat_r  <= squat_nxt;
      saccel_r <= saccel_nxt;
    end
  end

endmodule

/* rtl/imd_out_reg.sv */
// ----------------------------------------------------------------------------
// imd_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module imd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  imd_pkg::result_t load_data,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output imd_pkg::result_t out_data
);
  import imd_pkg::*;

  logic    vld_r, vld_nxt;
  result_t data_r;

  // Free when empty or when the held request leaves this cycle
  assign room = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (room) vld_nxt = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture payload only on a new request
  always_ff @(posedge clk) begin
    if (room && load) data_r <= load_data;
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

/* tb/sv/tb_imu_packet_deframer.sv */
// ----------------------------------------------------------------------------
// tb_imu_packet_deframer
// Self-checking bench for the IMU packet deframer. Feeds byte streams with
// sync hunts, tagged record bodies, empty, truncated and corrupt packets,
// mirrors the parser in a byte-level model and compares every emitted
// reading field by field, under random idle and stall on both sides.
// ----------------------------------------------------------------------------
module tb_imu_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import imd_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int END_CYCLES  = 8;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic [31:0] out_accel_x, out_accel_y, out_accel_z;
  logic [31:0] out_packet_seq;

  // Idle control shared between the test tasks and the stall process
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off_req = 1'b0;
  int unsigned hold_left = 0;

  int unsigned bytes_taken = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  // Parser mirror state
  logic [15:0] hunt_win = '0;
  phase_t      parse_ph = PH_HUNT;
  logic [7:0]  keep_chk = '0;
  logic [7:0]  body_len = '0;
  logic [7:0]  body_cnt = '0;
  logic [7:0]  body_or = '0;
  rkind_t      rec_kind = RK_TAG;
  logic [4:0]  rec_off = '0;
  logic [31:0] stage_quat[4] = '{default: '0};
  logic [31:0] stage_accel[3] = '{default: '0};
  logic        stage_quat_ok = 1'b0;
  logic        stage_accel_ok = 1'b0;
  logic [31:0] hold_quat[4] = '{default: '0};
  logic [31:0] hold_accel[3] = '{default: '0};
  logic [31:0] frames_ok = '0;

  result_t readings_due[$];

  imu_packet_deframer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_quat_w     (out_quat_w),
    .out_quat_x     (out_quat_x),
    .out_quat_y     (out_quat_y),
    .out_quat_z     (out_quat_z),
    .out_accel_x    (out_accel_x),
    .out_accel_y    (out_accel_y),
    .out_accel_z    (out_accel_z),
    .out_packet_seq (out_packet_seq)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser mirror
  // ---------------------------------------------------------------------------

  // Drop all per-packet state and restart the hunt from a cleared window
  function automatic void restart_hunt();
    hunt_win = '0;
    parse_ph = PH_HUNT;
    keep_chk = '0;
    body_len = '0;
    body_cnt = '0;
    body_or = '0;
    rec_kind = RK_TAG;
    rec_off = '0;
    stage_quat_ok = 1'b0;
    stage_accel_ok = 1'b0;
  endfunction

  // Commit staged records and queue a reading when the check byte matches
  function automatic void close_packet();
    result_t r;
    if (body_or == keep_chk) begin
      if (stage_quat_ok) hold_quat = stage_quat;
      if (stage_accel_ok) hold_accel = stage_accel;
      r.quat_w = hold_quat[0];
      r.quat_x = hold_quat[1];
      r.quat_y = hold_quat[2];
      r.quat_z = hold_quat[3];
      r.accel_x = hold_accel[0];
      r.accel_y = hold_accel[1];
      r.accel_z = hold_accel[2];
      r.packet_seq = frames_ok;
      readings_due.push_back(r);
      frames_ok++;
    end
    restart_hunt();
  endfunction

  // Advance the record parser by one body byte
  function automatic void record_byte(logic [7:0] b);
    case (rec_kind)
      RK_QUAT: begin
        stage_quat[rec_off[3:2]][8 * rec_off[1:0] +: 8] = b;
        rec_off++;
        if (rec_off >= QUAT_BYTES) begin
          stage_quat_ok = 1'b1;
          rec_kind = RK_TAG;
        end
      end
      RK_ACCEL: begin
        stage_accel[rec_off[3:2]][8 * rec_off[1:0] +: 8] = b;
        rec_off++;
        if (rec_off >= ACCEL_BYTES) begin
          stage_accel_ok = 1'b1;
          rec_kind = RK_TAG;
        end
      end
      RK_SKIP12: begin
        rec_off++;
        if (rec_off >= SKIP12_BYTES) rec_kind = RK_TAG;
      end
      RK_SKIPT: begin
        rec_off++;
        if (rec_off >= TIME_BYTES) rec_kind = RK_TAG;
      end
      default: begin
        rec_off = '0;
        case (b)
          TAG_QUAT: begin
            rec_kind = RK_QUAT;
            stage_quat_ok = 1'b0;
          end
          TAG_ACCEL: begin
            rec_kind = RK_ACCEL;
            stage_accel_ok = 1'b0;
          end
          TAG_SKIP_A, TAG_SKIP_B: rec_kind = RK_SKIP12;
          TAG_TIME: rec_kind = RK_SKIPT;
          default: rec_kind = RK_TAG;
        endcase
      end
    endcase
  endfunction

  // Advance the whole deframer by one accepted byte
  function automatic void deframe_byte(logic [7:0] b);
    case (parse_ph)
      PH_HUNT: begin
        if (hunt_win == {SYNC_B0, SYNC_B1} && b == SYNC_B2) begin
          hunt_win = '0;
          parse_ph = PH_CHK0;
        end else begin
          hunt_win = {hunt_win[7:0], b};
        end
      end
      PH_CHK0: parse_ph = PH_CHK1;
      PH_CHK1: begin
        keep_chk = b;
        parse_ph = PH_LEN;
      end
      PH_LEN: begin
        body_len = b;
        body_cnt = '0;
        body_or = '0;
        rec_kind = RK_TAG;
        rec_off = '0;
        if (b == 8'h00) close_packet();
        else parse_ph = PH_BODY;
      end
      PH_BODY: begin
        body_or |= b;
        record_byte(b);
        body_cnt++;
        if (body_cnt >= body_len) close_packet();
      end
      default: restart_hunt();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall, check, watchdog
  // ---------------------------------------------------------------------------

  // Drive stall: a requested hold-off wins over random stalls
  always @(negedge clk) begin
    if (hold_off_req) begin
      hold_left = HOLD_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endfunction

  // Compare each accepted reading with the oldest one due
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected reading, packet_seq %h", out_packet_seq);
      end else begin
        want = readings_due.pop_front();
        check_field("quat_w", want.quat_w, out_quat_w);
        check_field("quat_x", want.quat_x, out_quat_x);
        check_field("quat_y", want.quat_y, out_quat_y);
        check_field("quat_z", want.quat_z, out_quat_z);
        check_field("accel_x", want.accel_x, out_accel_x);
        check_field("accel_y", want.accel_y, out_accel_y);
        check_field("accel_z", want.accel_z, out_accel_z);
        check_field("packet_seq", want.packet_seq, out_packet_seq);
      end
    end
  end

  // Stop the run when neither side moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL imu_packet_deframer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one byte request and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    deframe_byte(b);
    bytes_taken++;
  endtask

  task automatic send_raw(input byte_q_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Sync, check bytes, length and body; corrupt flips one check bit
  task automatic send_frame(input byte_q_t body, input bit corrupt);
    logic [7:0] orv;
    orv = '0;
    foreach (body[i]) orv |= body[i];
    if (corrupt) orv ^= 8'h01 << $urandom_range(7);
    send_byte(SYNC_B0);
    send_byte(SYNC_B1);
    send_byte(SYNC_B2);
    send_byte(8'($urandom));
    send_byte(orv);
    send_byte(8'(body.size()));
    foreach (body[i]) send_byte(body[i]);
  endtask

  // Drop valid and wait until every reading due has been taken
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (readings_due.size() != 0);
  endtask

  // Append a little-endian word
  function automatic void add_word(inout byte_q_t q, input logic [31:0] w);
    for (int i = 0; i < 4; i++) q.push_back(w[8 * i +: 8]);
  endfunction

  // Append a tag and a random payload of the length that the tag implies
  function automatic void add_record(inout byte_q_t q, input logic [7:0] tag,
                                     input logic [7:0] mask);
    int n;
    case (tag)
      TAG_QUAT: n = QUAT_BYTES;
      TAG_ACCEL, TAG_SKIP_A, TAG_SKIP_B: n = ACCEL_BYTES;
      TAG_TIME: n = TIME_RECORD_BYTES;
      default: n = 0;
    endcase
    q.push_back(tag);
    for (int i = 0; i < n; i++) q.push_back(8'($urandom) & mask);
  endfunction

  function automatic logic [7:0] pick_tag();
    case ($urandom_range(9))
      0, 1, 2: return TAG_QUAT;
      3, 4, 5: return TAG_ACCEL;
      6: return $urandom_range(1) ? TAG_SKIP_A : TAG_SKIP_B;
      7: return TAG_TIME;
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // False starts, then a sync on overlapping bytes and an empty good packet
  task automatic test_sync_hunt();
    byte_q_t s;
    s = '{8'h00, 8'hFF, 8'hF0, 8'hF0, 8'h00, 8'hFF, 8'hFF, 8'hF0, 8'h00,
          8'h37, 8'h00, 8'h00};
    send_raw(s);
    wait_all_results();
  endtask

  // Empty body: accepted with a zero check byte, dropped otherwise
  task automatic test_empty_body();
    byte_q_t body;
    send_frame(body, 1'b0);
    send_frame(body, 1'b1);
    wait_all_results();
  endtask

  // Every tag kind in one packet, with extreme word values
  task automatic test_record_tags();
    byte_q_t body;
    body.push_back(TAG_QUAT);
    add_word(body, 32'h0000_0000);
    add_word(body, 32'hFFFF_FFFF);
    add_word(body, 32'h8000_0001);
    add_word(body, 32'h7F80_0000);
    body.push_back(TAG_ACCEL);
    add_word(body, 32'hFFFF_FFFF);
    add_word(body, 32'h0000_0000);
    add_word(body, 32'hA5A5_5A5A);
    add_record(body, TAG_SKIP_A, 8'hFF);
    add_record(body, TAG_SKIP_B, 8'hFF);
    add_record(body, TAG_TIME, 8'hFF);
    body.push_back(8'h00);
    body.push_back(8'hFF);
    body.push_back(8'h03);
    send_frame(body, 1'b0);
    wait_all_results();
  endtask

  // A record cut by the body end is dropped along with an earlier one
  task automatic test_truncated_record();
    byte_q_t body;
    add_record(body, TAG_QUAT, 8'hFF);
    add_record(body, TAG_ACCEL, 8'hFF);
    add_record(body, TAG_QUAT, 8'hFF);
    while (body.size() > 38) void'(body.pop_back());
    send_frame(body, 1'b0);
    body.delete();
    add_record(body, TAG_ACCEL, 8'h3C);
    void'(body.pop_back());
    send_frame(body, 1'b0);
    wait_all_results();
  endtask

  // The last complete record of each kind wins
  task automatic test_repeated_record();
    byte_q_t body;
    add_record(body, TAG_QUAT, 8'hFF);
    add_record(body, TAG_ACCEL, 8'hFF);
    add_record(body, TAG_QUAT, 8'h0F);
    add_record(body, TAG_ACCEL, 8'hF0);
    send_frame(body, 1'b0);
    wait_all_results();
  endtask

  // A corrupt packet commits nothing; the next empty one shows held values
  task automatic test_corrupt_packet();
    byte_q_t body, none;
    add_record(body, TAG_QUAT, 8'hFF);
    add_record(body, TAG_ACCEL, 8'hFF);
    send_frame(body, 1'b1);
    send_frame(none, 1'b0);
    wait_all_results();
  endtask

  // Body ending in the first two sync bytes must not carry over to the hunt
  task automatic test_hunt_restart();
    byte_q_t body, s;
    body = '{SYNC_B0, SYNC_B1};
    send_frame(body, 1'b0);
    s = '{SYNC_B2, 8'h00, SYNC_B0, SYNC_B1, SYNC_B2, 8'h11, 8'h00, 8'h00};
    send_raw(s);
    wait_all_results();
  endtask

  // Longest body the length byte allows
  task automatic test_max_length();
    byte_q_t body;
    while (body.size() < 255) add_record(body, pick_tag(), 8'hFF);
    while (body.size() > 255) void'(body.pop_back());
    send_frame(body, 1'b0);
    wait_all_results();
  endtask

  // Hold the receiver off while short packets keep coming
  task automatic test_output_hold();
    byte_q_t none;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 10; i++) send_frame(none, 1'b0);
    wait_all_results();
  endtask

  // Mostly well-formed packets with random content, some noise and damage
  task automatic test_random_stream(input int unsigned idle_in, input int unsigned idle_out,
                                    input int unsigned n_bytes, input int unsigned n_frames);
    int unsigned byte_mark, frame_mark;
    byte_q_t body, noise;
    logic [7:0] mask;
    send_idle_pct = idle_in;
    recv_stall_pct = idle_out;
    byte_mark = bytes_taken;
    frame_mark = frames_ok;
    while (bytes_taken - byte_mark < n_bytes || frames_ok - frame_mark < n_frames) begin
      noise.delete();
      body.delete();
      // leading noise or a broken sync
      case ($urandom_range(9))
        0: for (int i = $urandom_range(1, 5); i > 0; i--) noise.push_back(8'($urandom));
        1: noise = '{SYNC_B0, SYNC_B1, 8'($urandom_range(1, 255))};
        default: ;
      endcase
      send_raw(noise);
      mask = $urandom_range(1) ? 8'hFF : 8'($urandom);
      for (int i = $urandom_range(4); i > 0; i--) add_record(body, pick_tag(), mask);
      if (body.size() > 0 && $urandom_range(99) < 15)
        while (body.size() > 0 && $urandom_range(3) != 0) void'(body.pop_back());
      send_frame(body, $urandom_range(99) < 15);
    end
    wait_all_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 8;
    recv_stall_pct = 68;
    test_sync_hunt();
    test_empty_body();
    test_record_tags();
    test_truncated_record();
    test_repeated_record();
    test_corrupt_packet();
    test_hunt_restart();
    test_max_length();
    test_output_hold();

    test_random_stream(8, 68, 40, 1);
    test_random_stream(68, 8, 40, 1);
    test_random_stream(0, 0, 40, 1);

    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS imu_packet_deframer");
    end else begin
      $display("FAIL imu_packet_deframer");
    end
    $finish;
  end

endmodule
